FILE: hdl/hps_pkg.sv
package hps_pkg;

   localparam int unsigned DEFAULT_COUNTER_BITS = 40;
   localparam int unsigned COUNT_OUT_BITS = 40;
   localparam logic [30:0] LIMIT_RESET = 31'h477D_E800;
   localparam logic [31:0] ONE_BITS = 32'h3F80_0000;

   function automatic logic is_nonfinite(input logic [31:0] v);
      return (v[30:23] == 8'hFF);
   endfunction

endpackage

FILE: hdl/hdr_pixel_sanitizer_core.sv
// Sanitizes one RGBA float32 pixel per request and reports running statistics.
// Input channel req_*: four channel bit patterns plus req_start_of_image, which
// clears the statistics before the pixel is counted. Result channel rsp_*:
// cleaned channels, the largest finite color value so far and three saturating
// counters (non-finite, negative, clamped) as they stand after the pixel.
// csr_clamp_limit is written whenever csr_write_enable is high; write it only
// while no request is in flight.
// A request is registered when accepted and offered on rsp_* in the cycle after.
// Throughput is one pixel per cycle without stalls, set by the single result
// register; the statistics update is a compare and an increment per channel.
// When the receiver stalls, the result register holds and req_ready stays low
// until the held result is taken; a new request is accepted in the same cycle
// the held result leaves. Reset clears the statistics, drops rsp_valid and
// loads the limit with 65000.0.
module hdr_pixel_sanitizer_core #(
   parameter int unsigned COUNTER_BITS = hps_pkg::DEFAULT_COUNTER_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_red_in,
   input  logic [31:0] req_green_in,
   input  logic [31:0] req_blue_in,
   input  logic [31:0] req_alpha_in,
   input  logic        req_start_of_image,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_red_out,
   output logic [31:0] rsp_green_out,
   output logic [31:0] rsp_blue_out,
   output logic [31:0] rsp_alpha_out,
   output logic [30:0] rsp_max_finite,
   output logic [hps_pkg::COUNT_OUT_BITS-1:0] rsp_nonfinite_count,
   output logic [hps_pkg::COUNT_OUT_BITS-1:0] rsp_negative_count,
   output logic [hps_pkg::COUNT_OUT_BITS-1:0] rsp_clamped_count,
   input  logic        csr_write_enable,
   input  logic [30:0] csr_clamp_limit
);
   import hps_pkg::*;

   localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;

   logic [30:0] limit_ff;
   logic [30:0] max_ff, max_in;
   logic [COUNTER_BITS-1:0] nf_ff, nf_in, neg_ff, neg_in, clp_ff, clp_in;
   logic        valid_ff;
   logic [31:0] red_ff, green_ff, blue_ff, alpha_ff;
   logic [31:0] red_in, green_in, blue_in, alpha_in;
   logic        accept;

   assign req_ready = !valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // Limit register.
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_write_enable) begin
         limit_ff <= csr_clamp_limit;
      end
   end

   // Per-pixel cleaning and statistics, channels taken red, green, blue.
   always_comb begin
      logic [31:0] v [3];
      logic [31:0] o [3];
      logic [COUNTER_BITS-1:0] nf, ng, cl;
      logic [30:0] mx;
      v[0] = req_red_in;
      v[1] = req_green_in;
      v[2] = req_blue_in;
      mx = req_start_of_image ? '0 : max_ff;
      nf = req_start_of_image ? '0 : nf_ff;
      ng = req_start_of_image ? '0 : neg_ff;
      cl = req_start_of_image ? '0 : clp_ff;
      for (int i = 0; i < 3; i++) begin
         o[i] = v[i];
         if (is_nonfinite(v[i])) begin
            o[i] = '0;
            if (nf != CNT_MAX) nf = nf + 1'b1;
         end else if (v[i][31]) begin
            if (v[i][30:0] != '0) begin
               o[i] = '0;
               if (ng != CNT_MAX) ng = ng + 1'b1;
            end
         end else begin
            if (v[i][30:0] > mx) mx = v[i][30:0];
            if (v[i][30:0] > limit_ff) begin
               o[i] = {1'b0, limit_ff};
               if (cl != CNT_MAX) cl = cl + 1'b1;
            end
         end
      end
      red_in   = o[0];
      green_in = o[1];
      blue_in  = o[2];
      max_in = mx;
      nf_in  = nf;
      neg_in = ng;
      clp_in = cl;
      // Alpha clamp to [0,1].
      if (is_nonfinite(req_alpha_in)) begin
         alpha_in = ONE_BITS;
      end else if (req_alpha_in[31]) begin
         alpha_in = (req_alpha_in[30:0] != '0) ? '0 : req_alpha_in;
      end else if (req_alpha_in > ONE_BITS) begin
         alpha_in = ONE_BITS;
      end else begin
         alpha_in = req_alpha_in;
      end
   end

   // Statistics and result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         max_ff   <= '0;
         nf_ff    <= '0;
         neg_ff   <= '0;
         clp_ff   <= '0;
      end else begin
         if (accept) begin
            valid_ff <= 1'b1;
            max_ff   <= max_in;
            nf_ff    <= nf_in;
            neg_ff   <= neg_in;
            clp_ff   <= clp_in;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
         alpha_ff <= alpha_in;
      end
   end

   function automatic logic [COUNT_OUT_BITS-1:0] fit(input logic [COUNTER_BITS-1:0] c);
      logic [COUNTER_BITS+COUNT_OUT_BITS-1:0] w;
      w = {{COUNT_OUT_BITS{1'b0}}, c};
      return w[COUNT_OUT_BITS-1:0];
   endfunction

   assign rsp_valid           = valid_ff;
   assign rsp_red_out         = red_ff;
   assign rsp_green_out       = green_ff;
   assign rsp_blue_out        = blue_ff;
   assign rsp_alpha_out       = alpha_ff;
   assign rsp_max_finite      = max_ff;
   assign rsp_nonfinite_count = fit(nf_ff);
   assign rsp_negative_count  = fit(neg_ff);
   assign rsp_clamped_count   = fit(clp_ff);

   // A held result must not be overwritten.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !rsp_ready |=> valid_ff && $stable(red_ff) && $stable(nf_ff))
      else $error("result changed while stalled");
   // Counters only move on an accepted request.
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(nf_ff) && $stable(neg_ff) && $stable(clp_ff) && $stable(max_ff))
      else $error("statistics moved without a request");
   // Without a restart the maximum never decreases.
   a_max: assert property (@(posedge clock) disable iff (reset)
      accept && !req_start_of_image |=> max_ff >= $past(max_ff))
      else $error("maximum decreased");
   // The cleaned red channel is never negative nonzero or non-finite.
   a_clean: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> !is_nonfinite(red_ff) && !(red_ff[31] && red_ff[30:0] != '0))
      else $error("red not cleaned");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

// Scoreboard for the pixel sanitizer: it keeps its own copy of the limit and the
// running statistics, and queues the sanitized pixel expected for each request.
class pixel_scoreboard;
   typedef struct packed {
      logic [31:0] red;
      logic [31:0] green;
      logic [31:0] blue;
      logic [31:0] alpha;
      logic [30:0] max_finite;
      logic [39:0] nonfinite;
      logic [39:0] negative;
      logic [39:0] clamped;
   } pixel_result_type;

   localparam logic [39:0] COUNT_MAX = {40{1'b1}};

   logic [30:0] limit;
   logic [31:0] max_seen;
   logic [39:0] nonfinite_total;
   logic [39:0] negative_total;
   logic [39:0] clamped_total;
   pixel_result_type pending[$];
   int mismatches;
   int checked;

   function new();
      limit = hps_pkg::LIMIT_RESET;
      max_seen = '0;
      nonfinite_total = '0;
      negative_total = '0;
      clamped_total = '0;
      mismatches = 0;
      checked = 0;
   endfunction

   function void set_limit(logic [30:0] value);
      limit = value;
   endfunction

   // Cleans one color channel and updates the statistics.
   function logic [31:0] clean_color(logic [31:0] v);
      if (v[30:23] == 8'hFF) begin
         if (nonfinite_total != COUNT_MAX) nonfinite_total++;
         return 32'h0;
      end
      if (!v[31] && v > max_seen) max_seen = v;
      if (v[31]) begin
         if (v[30:0] != 0) begin
            if (negative_total != COUNT_MAX) negative_total++;
            return 32'h0;
         end
         return v;
      end
      if (v > {1'b0, limit}) begin
         if (clamped_total != COUNT_MAX) clamped_total++;
         return {1'b0, limit};
      end
      return v;
   endfunction

   function logic [31:0] clean_alpha(logic [31:0] a);
      if (a[30:23] == 8'hFF) return hps_pkg::ONE_BITS;
      if (a[31]) return (a[30:0] != 0) ? 32'h0 : a;
      if (a > hps_pkg::ONE_BITS) return hps_pkg::ONE_BITS;
      return a;
   endfunction

   // Notes an accepted request and queues its expected result.
   function void note_request(logic [31:0] r, logic [31:0] g, logic [31:0] b,
                              logic [31:0] a, logic start);
      pixel_result_type res;
      if (start) begin
         max_seen = '0;
         nonfinite_total = '0;
         negative_total = '0;
         clamped_total = '0;
      end
      res.red = clean_color(r);
      res.green = clean_color(g);
      res.blue = clean_color(b);
      res.alpha = clean_alpha(a);
      res.max_finite = max_seen[30:0];
      res.nonfinite = nonfinite_total;
      res.negative = negative_total;
      res.clamped = clamped_total;
      pending = {pending, res};
   endfunction

   // Compares an accepted result with the oldest expectation.
   function void check_result(pixel_result_type got);
      pixel_result_type want;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("ERROR: result with nothing expected: %h", got);
         return;
      end
      want = pending.pop_front();
      checked++;
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("ERROR: result %0d mismatch", checked);
            $display("  expected r=%h g=%h b=%h a=%h max=%h nf=%h neg=%h clp=%h",
                     want.red, want.green, want.blue, want.alpha, want.max_finite,
                     want.nonfinite, want.negative, want.clamped);
            $display("  actual   r=%h g=%h b=%h a=%h max=%h nf=%h neg=%h clp=%h",
                     got.red, got.green, got.blue, got.alpha, got.max_finite,
                     got.nonfinite, got.negative, got.clamped);
         end
      end
   endfunction
endclass

module testbench;
   localparam int WATCHDOG_LIMIT = 2000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [31:0] req_red_in;
   logic [31:0] req_green_in;
   logic [31:0] req_blue_in;
   logic [31:0] req_alpha_in;
   logic req_start_of_image;
   logic rsp_valid;
   logic rsp_ready;
   logic [31:0] rsp_red_out;
   logic [31:0] rsp_green_out;
   logic [31:0] rsp_blue_out;
   logic [31:0] rsp_alpha_out;
   logic [30:0] rsp_max_finite;
   logic [39:0] rsp_nonfinite_count;
   logic [39:0] rsp_negative_count;
   logic [39:0] rsp_clamped_count;
   logic csr_write_enable;
   logic [30:0] csr_clamp_limit;

   pixel_scoreboard board;
   bit idle_enabled;
   int stall_cycles;
   int requests_sent;
   int image_starts;

   hdr_pixel_sanitizer_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_red_in(req_red_in), .req_green_in(req_green_in),
      .req_blue_in(req_blue_in), .req_alpha_in(req_alpha_in),
      .req_start_of_image(req_start_of_image),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_red_out(rsp_red_out), .rsp_green_out(rsp_green_out),
      .rsp_blue_out(rsp_blue_out), .rsp_alpha_out(rsp_alpha_out),
      .rsp_max_finite(rsp_max_finite),
      .rsp_nonfinite_count(rsp_nonfinite_count),
      .rsp_negative_count(rsp_negative_count),
      .rsp_clamped_count(rsp_clamped_count),
      .csr_write_enable(csr_write_enable), .csr_clamp_limit(csr_clamp_limit)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Result side: random stalls on ready, checks on each accepted result.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_result({rsp_red_out, rsp_green_out, rsp_blue_out, rsp_alpha_out,
                             rsp_max_finite, rsp_nonfinite_count,
                             rsp_negative_count, rsp_clamped_count});
   end

   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= !(idle_enabled && $urandom_range(99) < 28);
   end

   // Watchdog: counts cycles without any handshake.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results pending", board.pending.size());
            $display("simulation failed");
            $finish;
         end
      end
   end

   // Sends one pixel request and waits for its acceptance. Valid stays high
   // afterwards so that requests can follow back to back; idle cycles drop it.
   task automatic send_pixel(logic [31:0] r, logic [31:0] g, logic [31:0] b,
                             logic [31:0] a, logic start);
      while (idle_enabled && $urandom_range(99) < 28) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_red_in <= r;
      req_green_in <= g;
      req_blue_in <= b;
      req_alpha_in <= a;
      req_start_of_image <= start;
      do @(posedge clock); while (!req_ready);
      board.note_request(r, g, b, a, start);
      requests_sent++;
      if (start) image_starts++;
      @(negedge clock);
   endtask

   // Waits until every expected result has come back, then writes the limit.
   task automatic write_limit(logic [30:0] value);
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_clamp_limit <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      board.set_limit(value);
   endtask

   // Random float pattern biased toward the interesting classes.
   function automatic logic [31:0] pick_float();
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(9))
         0: v[30:23] = 8'hFF;
         1: v = {v[31], 31'h0};
         2: v[30:23] = 8'(32'h7E + $urandom_range(0, 1));
         3: v = {1'b0, 8'h8E, v[22:0]};
         4: v[30:23] = 8'h00;
         default: ;
      endcase
      return v;
   endfunction

   task automatic random_phase(int count);
      for (int i = 0; i < count; i++)
         send_pixel(pick_float(), pick_float(), pick_float(), pick_float(),
                    $urandom_range(39) == 0);
   endtask

   initial begin
      board = new();
      idle_enabled = 1'b0;
      stall_cycles = 0;
      requests_sent = 0;
      image_starts = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_red_in = '0;
      req_green_in = '0;
      req_blue_in = '0;
      req_alpha_in = '0;
      req_start_of_image = 1'b0;
      rsp_ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_clamp_limit = '0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Directed pixels under the default limit, back to back.
      send_pixel(32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h8000_0000, 1'b1);
      send_pixel(32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0001, 32'hFFFF_FFFF, 1'b0);
      send_pixel(32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h477D_E801, 32'h7F80_0000, 1'b0);
      send_pixel(32'h477D_E800, 32'h3F80_0000, 32'hBF80_0000, 32'h3F80_0001, 1'b0);
      send_pixel(32'h8000_0001, 32'h0080_0000, 32'h4000_0000, 32'h3F80_0000, 1'b0);
      send_pixel(32'h3F00_0000, 32'h3F00_0000, 32'h3F00_0000, 32'hBF00_0000, 1'b0);
      send_pixel(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 1'b1);
      send_pixel(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 32'h3E00_0000, 1'b0);

      // Zero limit: every positive finite nonzero value clamps to +0.
      write_limit(31'h0);
      send_pixel(32'h0000_0001, 32'h3F80_0000, 32'h0000_0000, 32'h4000_0000, 1'b1);
      send_pixel(32'h7F7F_FFFF, 32'h8000_0000, 32'h8000_0005, 32'h0000_0000, 1'b0);
      idle_enabled = 1'b1;
      random_phase(100);

      // Infinity and NaN limits: nothing clamps.
      write_limit(31'h7F80_0000);
      send_pixel(32'h7F7F_FFFF, 32'h7F00_0000, 32'h0000_0001, 32'h3F80_0000, 1'b1);
      random_phase(60);
      write_limit(31'h7FFF_FFFF);
      random_phase(60);

      // Largest legal limit, then a small one, then back to the default.
      write_limit(31'h7F7F_FFFF);
      random_phase(80);
      write_limit(31'h3F80_0000);
      random_phase(100);
      idle_enabled = 1'b0;
      random_phase(80);
      idle_enabled = 1'b1;
      write_limit(hps_pkg::LIMIT_RESET);
      random_phase(100);
      req_valid <= 1'b0;

      while (board.pending.size() != 0) @(negedge clock);
      repeat (5) @(negedge clock);
      $display("Sent %0d pixels in %0d images over six clamp limits, %0d results checked.",
               requests_sent, image_starts, board.checked);
      if (board.mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d mismatches", board.mismatches);
         $display("simulation failed");
      end
      $finish;
   end
endmodule

FILE: files.f
hdl/hps_pkg.sv
hdl/hdr_pixel_sanitizer_core.sv
tb/sv/testbench.sv
